[sv/wlpc_pkg.sv]
`default_nettype none
package wlpc_pkg;

  localparam int RING_DEPTH_DEF = 16;

  localparam logic [4:0]  HIGH_SLOT  = 5'd16;
  localparam logic [7:0]  BYTE_MAX   = 8'hff;
  localparam logic [23:0] COUNT_MAX  = 24'hffffff;

  typedef enum logic [1:0] {
    ACT_READ   = 2'd0,
    ACT_INC    = 2'd1,
    ACT_PRESET = 2'd2,
    ACT_FORGET = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN_FIRST,
    ST_SCAN,
    ST_REPLY,
    ST_INC
  } state_t;

  typedef struct packed {
    action_t     action;
    logic [4:0]  slot;
    logic [15:0] value;
  } request_t;

  typedef struct packed {
    logic [23:0] count;
    logic        overflow;
    logic [3:0]  position;
  } result_t;

endpackage
`default_nettype wire

[sv/wear_leveled_persistent_counter_core.sv]
`default_nettype none
// 24-bit counter with a wear-levelled low byte: the upper 16 bits sit in one word, the low
// byte moves round a ring of RING_DEPTH slots held in a synchronous RAM with one read port and
// one write port. A command is taken when start is high and busy is low; every command
// (read, increment, preset, forget) makes one RAM read and waits for its registered return,
// and its result appears on result for exactly one cycle with done high, the cycle after.
// The first read or increment after reset or a forget first scans the ring through the same
// read port, in states ST_SCAN_FIRST and ST_SCAN. The ring is cleared at reset by per-slot
// valid bits, so no clearing pass is needed. Results cannot be held off by the receiver.
module wear_leveled_persistent_counter_core #(
  parameter int RING_DEPTH = wlpc_pkg::RING_DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire wlpc_pkg::request_t request,
  output logic                    done,
  output wlpc_pkg::result_t       result
);

  localparam int AW = $clog2(RING_DEPTH);

  logic          mem_rd_en;
  logic [AW-1:0] mem_rd_addr;
  logic [7:0]    mem_rd_data;
  logic          mem_wr_en;
  logic [AW-1:0] mem_wr_addr;
  logic [7:0]    mem_wr_data;

  wlpc_ctrl #(
    .RING_DEPTH(RING_DEPTH)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .request    (request),
    .done       (done),
    .result     (result),
    .mem_rd_en  (mem_rd_en),
    .mem_rd_addr(mem_rd_addr),
    .mem_rd_data(mem_rd_data),
    .mem_wr_en  (mem_wr_en),
    .mem_wr_addr(mem_wr_addr),
    .mem_wr_data(mem_wr_data)
  );

  wlpc_ring_mem #(
    .RING_DEPTH(RING_DEPTH)
  ) u_ring_mem (
    .clk    (clk),
    .rst    (rst),
    .rd_en  (mem_rd_en),
    .rd_addr(mem_rd_addr),
    .rd_data(mem_rd_data),
    .wr_en  (mem_wr_en),
    .wr_addr(mem_wr_addr),
    .wr_data(mem_wr_data)
  );

  a_accept_occupies: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted beat did not occupy the block");

  a_done_spaced: assert property (@(posedge clk) disable iff (rst)
    done |-> !$past(done))
    else $error("two results in consecutive cycles");

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result without a command in flight");

  a_overflow_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.overflow) |-> (result.count == '0))
    else $error("overflow flagged with non-zero count");

  a_single_write_idle: assert property (@(posedge clk) disable iff (rst)
    (mem_wr_en && !busy) |-> (start && (request.action == wlpc_pkg::ACT_PRESET)))
    else $error("ring write from idle without a preset");

endmodule
`default_nettype wire

[sv/wlpc_ring_mem.sv]
`default_nettype none
module wlpc_ring_mem #(
  parameter int RING_DEPTH = wlpc_pkg::RING_DEPTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          rd_en,
  input  wire logic [$clog2(RING_DEPTH)-1:0] rd_addr,
  output logic      [7:0]                    rd_data,
  input  wire logic                          wr_en,
  input  wire logic [$clog2(RING_DEPTH)-1:0] wr_addr,
  input  wire logic [7:0]                    wr_data
);

  logic [7:0]            mem [RING_DEPTH];
  logic [RING_DEPTH-1:0] valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // entries never written since reset read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr_en) begin
      valid[wr_addr] <= 1'b1;
    end
  end

  // forward a write to the same entry so the read sees the new byte
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data <= wr_data;
      end else if (valid[rd_addr]) begin
        rd_data <= mem[rd_addr];
      end else begin
        rd_data <= '0;
      end
    end
  end

endmodule
`default_nettype wire

[sv/wlpc_ctrl.sv]
`default_nettype none
module wlpc_ctrl #(
  parameter int RING_DEPTH = wlpc_pkg::RING_DEPTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire wlpc_pkg::request_t            request,
  output logic                               done,
  output wlpc_pkg::result_t                  result,
  output logic                               mem_rd_en,
  output logic      [$clog2(RING_DEPTH)-1:0] mem_rd_addr,
  input  wire logic [7:0]                    mem_rd_data,
  output logic                               mem_wr_en,
  output logic      [$clog2(RING_DEPTH)-1:0] mem_wr_addr,
  output logic      [7:0]                    mem_wr_data
);

  localparam int            AW        = $clog2(RING_DEPTH);
  localparam logic [AW-1:0] LAST_SLOT = AW'(RING_DEPTH - 1);

  wlpc_pkg::state_t  state, state_next;
  wlpc_pkg::action_t op_action;
  logic [AW-1:0]     ring_position;
  logic              known;
  logic [15:0]       high_word;
  logic [7:0]        last;
  logic [AW-1:0]     cmp_idx;

  logic              accept;
  logic              preset_ring;
  logic              scan_match;
  logic              scan_stop;
  logic [AW-1:0]     scan_pos;
  logic [23:0]       cur;
  logic [23:0]       incd;
  logic [AW-1:0]     inc_pos;

  assign accept      = start && (state == wlpc_pkg::ST_IDLE);
  assign preset_ring = (request.action == wlpc_pkg::ACT_PRESET)
                       && (request.slot != wlpc_pkg::HIGH_SLOT)
                       && (32'(request.slot) < RING_DEPTH);

  // scan keeps walking while bytes repeat or count up by one
  assign scan_match = (mem_rd_data == last + 8'd1);
  assign scan_stop  = (!scan_match && (mem_rd_data != last)) || (cmp_idx == LAST_SLOT);
  assign scan_pos   = scan_match ? cmp_idx : ring_position;

  assign cur     = {high_word, mem_rd_data};
  assign incd    = cur + 24'd1;
  assign inc_pos = (ring_position == LAST_SLOT) ? '0 : ring_position + 1'b1;

  always_comb begin
    state_next = state;
    unique case (state)
      wlpc_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (request.action)
            wlpc_pkg::ACT_READ:   state_next = known ? wlpc_pkg::ST_REPLY
                                                     : wlpc_pkg::ST_SCAN_FIRST;
            wlpc_pkg::ACT_INC:    state_next = known ? wlpc_pkg::ST_INC
                                                     : wlpc_pkg::ST_SCAN_FIRST;
            wlpc_pkg::ACT_PRESET: state_next = wlpc_pkg::ST_REPLY;
            wlpc_pkg::ACT_FORGET: state_next = wlpc_pkg::ST_REPLY;
          endcase
        end
      end
      wlpc_pkg::ST_SCAN_FIRST: state_next = wlpc_pkg::ST_SCAN;
      wlpc_pkg::ST_SCAN: begin
        if (scan_stop) begin
          state_next = (op_action == wlpc_pkg::ACT_INC) ? wlpc_pkg::ST_INC
                                                         : wlpc_pkg::ST_REPLY;
        end
      end
      wlpc_pkg::ST_REPLY: state_next = wlpc_pkg::ST_IDLE;
      wlpc_pkg::ST_INC:   state_next = wlpc_pkg::ST_IDLE;
      default:            state_next = wlpc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    busy        = (state != wlpc_pkg::ST_IDLE);
    mem_rd_en   = 1'b0;
    mem_rd_addr = ring_position;
    mem_wr_en   = 1'b0;
    mem_wr_addr = '0;
    mem_wr_data = '0;
    unique case (state)
      wlpc_pkg::ST_IDLE: begin
        if (accept) begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = (request.action == wlpc_pkg::ACT_FORGET) ? LAST_SLOT
                                                                   : ring_position;
          if (preset_ring) begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = AW'(request.slot);
            mem_wr_data = request.value[7:0];
          end
        end
      end
      wlpc_pkg::ST_SCAN_FIRST: begin
        mem_rd_en   = 1'b1;
        mem_rd_addr = '0;
      end
      wlpc_pkg::ST_SCAN: begin
        mem_rd_en   = 1'b1;
        mem_rd_addr = scan_stop ? scan_pos : cmp_idx + 1'b1;
      end
      wlpc_pkg::ST_INC: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = inc_pos;
        mem_wr_data = incd[7:0];
      end
      wlpc_pkg::ST_REPLY: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= wlpc_pkg::ST_IDLE;
      known         <= 1'b0;
      ring_position <= LAST_SLOT;
      high_word     <= '0;
      done          <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == wlpc_pkg::ST_REPLY) || (state == wlpc_pkg::ST_INC);
      unique case (state)
        wlpc_pkg::ST_IDLE: begin
          if (accept) begin
            if ((request.action == wlpc_pkg::ACT_PRESET)
                && (request.slot == wlpc_pkg::HIGH_SLOT)) begin
              high_word <= request.value;
            end
            if (request.action == wlpc_pkg::ACT_FORGET) begin
              known         <= 1'b0;
              ring_position <= LAST_SLOT;
            end
          end
        end
        wlpc_pkg::ST_SCAN: begin
          if (scan_match) begin
            ring_position <= cmp_idx;
          end
          if (scan_stop) begin
            known <= 1'b1;
          end
        end
        wlpc_pkg::ST_INC: begin
          ring_position <= inc_pos;
          // carry into the high word in the same cycle the ring byte is written
          if (mem_rd_data == wlpc_pkg::BYTE_MAX) begin
            high_word <= incd[23:8];
          end
        end
        wlpc_pkg::ST_SCAN_FIRST: begin
        end
        wlpc_pkg::ST_REPLY: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_action <= request.action;
    end
    if (state == wlpc_pkg::ST_SCAN_FIRST) begin
      last    <= mem_rd_data;
      cmp_idx <= '0;
    end else if ((state == wlpc_pkg::ST_SCAN) && !scan_stop) begin
      cmp_idx <= cmp_idx + 1'b1;
      if (scan_match) begin
        last <= mem_rd_data;
      end
    end
    if (state == wlpc_pkg::ST_REPLY) begin
      result.count    <= cur;
      result.overflow <= 1'b0;
      result.position <= 4'(ring_position);
    end else if (state == wlpc_pkg::ST_INC) begin
      result.count    <= incd;
      result.overflow <= (cur == wlpc_pkg::COUNT_MAX);
      result.position <= 4'(inc_pos);
    end
  end

endmodule
`default_nettype wire
